[hw/rtl/biu_pkg.sv]
// shared constants, types and functions of the bilinear image upscaler
package biu_pkg;

	localparam int MAX_ROWS   = 256;
	localparam int MAX_COLS   = 256;
	localparam int ROW_AW     = $clog2(MAX_ROWS);
	localparam int COL_AW     = $clog2(MAX_COLS);
	localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int SZ_W       = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);

	localparam int POS_W      = 12;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int CFG_SZ_W   = 9;
	localparam int IZ_W       = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int FRAC_W     = 16;
	localparam int PROD_W     = (2 * POS_W + 1 > POS_W + 1 + IZ_W) ? 2 * POS_W + 1
	                            : POS_W + 1 + IZ_W;
	localparam int BI_W       = PROD_W - FRAC_W;
	localparam int FOLD_W     = BI_W + 1;
	localparam int GW_W       = FRAC_W + 1;
	localparam int W_W        = 2 * FRAC_W + 1;
	localparam int ACC_W      = W_W + CH_W - 1;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_ZOOM = 2'd2;

	localparam logic [CFG_SZ_W-1:0] ROWS_RST = 9'd128;
	localparam logic [CFG_SZ_W-1:0] COLS_RST = 9'd128;
	localparam logic [IZ_W-1:0]     IZ_RST   = 20'd43691;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic       wr;
		logic       cap;
		logic       map;
		logic       idx;
		logic       rd;
		logic [1:0] rd_sel;
		logic       out_load;
	} biu_cmd_t;

	typedef struct packed {
		logic out_free;
	} biu_sts_t;

	// zero means one, above the maximum saturates
	function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_SZ_W-1:0] v,
	                                             input logic [SZ_W-1:0] mx);
		logic [SZ_W+CFG_SZ_W-1:0] ve;
		logic [SZ_W+CFG_SZ_W-1:0] me;
		ve = (SZ_W+CFG_SZ_W)'(v);
		me = (SZ_W+CFG_SZ_W)'(mx);
		if (v == '0) return SZ_W'(1);
		else if (ve > me) return mx;
		else return SZ_W'(v);
	endfunction

	// biased index (index + 1) folded into 0 .. size-1
	function automatic logic [SZ_W-1:0] fold_idx(input logic [FOLD_W-1:0] b,
	                                             input logic [SZ_W-1:0] sz);
		logic [FOLD_W-1:0] m;
		m = b - FOLD_W'(1);
		if (b == '0) return '0;
		else if (m >= FOLD_W'(sz)) return sz - SZ_W'(1);
		else return SZ_W'(m);
	endfunction

endpackage

[hw/rtl/biu_if.sv]
// request and result channel interfaces
interface biu_in_if import biu_pkg::*;;
	logic              valid;
	logic              ready;
	logic              op;
	logic [POS_W-1:0]  row;
	logic [POS_W-1:0]  col;
	logic [CH_W-1:0]   pixel_ch0;
	logic [CH_W-1:0]   pixel_ch1;
	logic [CH_W-1:0]   pixel_ch2;

	modport source (output valid, op, row, col, pixel_ch0, pixel_ch1, pixel_ch2,
	                input ready);
	modport sink (input valid, op, row, col, pixel_ch0, pixel_ch1, pixel_ch2,
	              output ready);
endinterface

interface biu_out_if import biu_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_ch0;
	logic [CH_W-1:0] out_ch1;
	logic [CH_W-1:0] out_ch2;

	modport source (output valid, out_ch0, out_ch1, out_ch2, input ready);
	modport sink (input valid, out_ch0, out_ch1, out_ch2, output ready);
endinterface

[hw/rtl/biu_ctrl.sv]
// controller state machine sequencing writes and queries
module biu_ctrl import biu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_op,
	output logic     req_ready,
	input  biu_sts_t sts,
	output biu_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAP  = 3'd1;
	localparam logic [2:0] ST_IDX  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_LAST = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] cnt_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_op == OP_QUERY) begin
						cmd.cap = 1'b1;
						state_d = ST_MAP;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = ST_IDX;
			end
			ST_IDX: begin
				cmd.idx = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = cnt_q;
				if (cnt_q == 2'd3) state_d = ST_LAST;
			end
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_RD) ? cnt_q + 2'd1 : 2'd0;
		end
	end

endmodule

[hw/rtl/biu_dp.sv]
// datapath: config registers, image memory, position map, blend and result register
module biu_dp import biu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [POS_W-1:0]      req_row,
	input  logic [POS_W-1:0]      req_col,
	input  logic [PIX_W-1:0]      req_pix,
	input  biu_cmd_t              cmd,
	output biu_sts_t              sts,
	biu_out_if.source             rsp
);

	logic [CFG_SZ_W-1:0] rows_q;
	logic [CFG_SZ_W-1:0] cols_q;
	logic [IZ_W-1:0]     izoom_q;

	logic [POS_W-1:0]    row_q;
	logic [POS_W-1:0]    col_q;
	logic [PROD_W-1:0]   prod_r;
	logic [PROD_W-1:0]   prod_c;
	logic [PROD_W-1:0]   q_r;
	logic [PROD_W-1:0]   q_c;
	logic [BI_W-1:0]     bi_q;
	logic [BI_W-1:0]     bj_q;
	logic [FRAC_W-1:0]   fx_q;
	logic [FRAC_W-1:0]   fy_q;

	logic [SZ_W-1:0]     nr;
	logic [SZ_W-1:0]     nc;
	logic [SZ_W-1:0]     r0_f;
	logic [SZ_W-1:0]     r1_f;
	logic [SZ_W-1:0]     c0_f;
	logic [SZ_W-1:0]     c1_f;
	logic [GW_W-1:0]     gx;
	logic [GW_W-1:0]     gy;
	logic [ROW_AW-1:0]   r0_q;
	logic [ROW_AW-1:0]   r1_q;
	logic [COL_AW-1:0]   c0_q;
	logic [COL_AW-1:0]   c1_q;
	logic [W_W-1:0]      w_q [4];

	logic [PIX_W-1:0]    mem_q [MEM_DEPTH];
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;
	logic [ROW_AW-1:0]   rsel_r;
	logic [COL_AW-1:0]   rsel_c;
	logic                wr_ok;
	logic [PIX_W-1:0]    rdata_q;
	logic [1:0]          rsel_q;
	logic                rvld_q;

	logic [ACC_W-1:0]    acc_q [3];
	logic [ACC_W-1:0]    term [3];
	logic [W_W-1:0]      w_sel;

	logic                out_valid_q;
	logic [CH_W-1:0]     out_q [3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= ROWS_RST;
			cols_q  <= COLS_RST;
			izoom_q <= IZ_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SOURCE_ROWS:  rows_q  <= cfg_data[CFG_SZ_W-1:0];
				REG_SOURCE_COLS:  cols_q  <= cfg_data[CFG_SZ_W-1:0];
				REG_INVERSE_ZOOM: izoom_q <= cfg_data[IZ_W-1:0];
				default: ;
			endcase
		end
	end

	// query capture and position map
	assign prod_r = PROD_W'({row_q, 1'b1}) * PROD_W'(izoom_q);
	assign prod_c = PROD_W'({col_q, 1'b1}) * PROD_W'(izoom_q);
	assign q_r    = PROD_W'(prod_r[PROD_W-1:1]) + PROD_W'(1 << (FRAC_W - 1));
	assign q_c    = PROD_W'(prod_c[PROD_W-1:1]) + PROD_W'(1 << (FRAC_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			row_q <= req_row;
			col_q <= req_col;
		end
		if (cmd.map) begin
			bi_q <= q_r[PROD_W-1:FRAC_W];
			bj_q <= q_c[PROD_W-1:FRAC_W];
			fx_q <= q_r[FRAC_W-1:0];
			fy_q <= q_c[FRAC_W-1:0];
		end
	end

	// border fold and weights
	assign nr   = eff_size(rows_q, SZ_W'(MAX_ROWS));
	assign nc   = eff_size(cols_q, SZ_W'(MAX_COLS));
	assign r0_f = fold_idx(FOLD_W'(bi_q), nr);
	assign r1_f = fold_idx(FOLD_W'(bi_q) + FOLD_W'(1), nr);
	assign c0_f = fold_idx(FOLD_W'(bj_q), nc);
	assign c1_f = fold_idx(FOLD_W'(bj_q) + FOLD_W'(1), nc);
	assign gx   = GW_W'(1 << FRAC_W) - GW_W'(fx_q);
	assign gy   = GW_W'(1 << FRAC_W) - GW_W'(fy_q);

	always_ff @(posedge clk) begin
		if (cmd.idx) begin
			r0_q   <= r0_f[ROW_AW-1:0];
			r1_q   <= r1_f[ROW_AW-1:0];
			c0_q   <= c0_f[COL_AW-1:0];
			c1_q   <= c1_f[COL_AW-1:0];
			w_q[0] <= W_W'(gx) * W_W'(gy);
			w_q[1] <= W_W'(gx) * W_W'(fy_q);
			w_q[2] <= W_W'(fx_q) * W_W'(gy);
			w_q[3] <= W_W'(fx_q) * W_W'(fy_q);
		end
	end

	// image memory, one access a cycle
	assign wr_ok  = cmd.wr && ((POS_W + 1)'(req_row) < (POS_W + 1)'(MAX_ROWS))
	                       && ((POS_W + 1)'(req_col) < (POS_W + 1)'(MAX_COLS));
	assign waddr  = ADDR_W'(req_row[ROW_AW-1:0]) * ADDR_W'(MAX_COLS)
	              + ADDR_W'(req_col[COL_AW-1:0]);
	assign rsel_r = cmd.rd_sel[1] ? r1_q : r0_q;
	assign rsel_c = cmd.rd_sel[0] ? c1_q : c0_q;
	assign raddr  = ADDR_W'(rsel_r) * ADDR_W'(MAX_COLS) + ADDR_W'(rsel_c);

	always_ff @(posedge clk) begin
		if (wr_ok) mem_q[waddr] <= req_pix;
		if (cmd.rd) begin
			rdata_q <= mem_q[raddr];
			rsel_q  <= cmd.rd_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rvld_q <= 1'b0;
		else rvld_q <= cmd.rd;
	end

	// weighted accumulation per channel
	assign w_sel = w_q[rsel_q];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			term[ch] = ACC_W'(w_sel) * ACC_W'(rdata_q[ch*CH_W +: CH_W]);
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (cmd.idx) acc_q[ch] <= '0;
			else if (rvld_q) acc_q[ch] <= acc_q[ch] + term[ch];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int ch = 0; ch < 3; ch++) begin
				out_q[ch] <= acc_q[ch][ACC_W-1 -: CH_W];
			end
		end
	end

	assign sts.out_free = !out_valid_q || rsp.ready;
	assign rsp.valid    = out_valid_q;
	assign rsp.out_ch0  = out_q[0];
	assign rsp.out_ch1  = out_q[1];
	assign rsp.out_ch2  = out_q[2];

endmodule

[hw/rtl/bilinear_image_upscaler.sv]
// top level of the bilinear image upscaler
// a write item is stored as it is taken; one write per cycle while no query is in flight
// a query steps through map, index and weights, four reads of the single-port image
// memory, a drain and the output load, which waits until the output register is free;
// no new item is taken until the query is done
// reset clears control state and sets the registers to 128, 128 and 43691; the image is not cleared
module bilinear_image_upscaler import biu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	biu_in_if.sink                req,
	biu_out_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	biu_cmd_t cmd;
	biu_sts_t sts;

	biu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	biu_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req_row  (req.row),
		.req_col  (req.col),
		.req_pix  ({req.pixel_ch2, req.pixel_ch1, req.pixel_ch0}),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

	// a query blocks further items while it is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.op == OP_QUERY) |=> !req.ready)
		else $error("item taken while a query is in flight");

	// a write item never brings a result
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.op == OP_WRITE) && !rsp.valid |=> !rsp.valid)
		else $error("result appeared after a write item");

	// the result register is only loaded when free
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("result overwritten before it was taken");

	// memory reads happen only while no item can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !req.ready)
		else $error("image read while the input is open");

endmodule
